### hdl/process_generation_tracker_unit_assert.svh
// Assertion macros used by the tracker datapath.
// Each macro expects clk and rst in scope.
`ifndef PROCESS_GENERATION_TRACKER_UNIT_ASSERT_SVH
`define PROCESS_GENERATION_TRACKER_UNIT_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define PGT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define PGT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define PGT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pgt_pkg.sv
package pgt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Input commands
  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_END_SCAN = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOOKUP,
    S_DECIDE,
    S_READ_HIT,
    S_UPDATE,
    S_FIND_OUT,
    S_EOS_MARK,
    S_SORT_SCAN,
    S_SORT_READ,
    S_SORT_EMIT
  } state_t;

  // One stored entry apart from its pid
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] env;
    logic [63:0] name_lo;
    logic [63:0] name_hi;
    logic [31:0] gen;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_key;
    logic       scan_clr;
    logic       scan_step;
    logic       mode_sort;
    logic       rd_en;
    logic       rd_best;
    logic       ld_status;
    logic [2:0] status_code;
    logic       ld_new;
    logic       ld_upd;
    logic       ld_find;
    logic       ld_sort;
    logic       eos_mark;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       scan_done;
    logic       hit;
    logic       free_found;
    logic       out_free;
    logic       empty;
    logic       sort_last;
    logic       key_zero;
    logic [1:0] key_cmd;
  } stat_t;

endpackage

### hdl/pgt_req_if.sv
interface pgt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] pid;
  logic [63:0] page_base;
  logic [63:0] env_block;
  logic [63:0] name_lo;
  logic [63:0] name_hi;

  modport source (output valid, cmd, pid, page_base, env_block, name_lo, name_hi,
                  input ready);
  modport sink (input valid, cmd, pid, page_base, env_block, name_lo, name_hi,
                output ready);
endinterface

### hdl/pgt_rsp_if.sv
interface pgt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_pid;
  logic [63:0] out_page_base;
  logic [63:0] out_env_block;
  logic [63:0] out_name_lo;
  logic [63:0] out_name_hi;
  logic [31:0] generation;
  logic        exited;
  logic        last;

  modport source (output valid, status, out_pid, out_page_base, out_env_block,
                  out_name_lo, out_name_hi, generation, exited, last,
                  input ready);
  modport sink (input valid, status, out_pid, out_page_base, out_env_block,
                out_name_lo, out_name_hi, generation, exited, last,
                output ready);
endinterface

### hdl/process_generation_tracker_unit.sv
// Channel | Dir | Payload
// req     | in  | cmd, pid, page_base, env_block, name_lo, name_hi
// rsp     | out | status, out_pid, out_page_base, out_env_block, out_name_lo,
//         |     | out_name_hi, generation, exited, last
//
// Observe and find walk the pid memory once per item, with a read of the stored
// entry when the pid is found. An ignored item or unused command skips the walk.
// End of scan does one selection walk per stored entry, each walk going
// through the single pid read port.
// Synchronous reset clears occupancy and seen marks.
// A result waits in the output register; the block stalls only when a second
// result is ready before the first is taken.
module process_generation_tracker_unit (
  input  logic      clk,
  input  logic      rst,
  pgt_req_if.sink   req,
  pgt_rsp_if.source rsp
);

  pgt_pkg::cmd_t  cmd;
  pgt_pkg::stat_t stat;

  pgt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pgt_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_cmd       (req.cmd),
    .in_pid       (req.pid),
    .in_page_base (req.page_base),
    .in_env_block (req.env_block),
    .in_name_lo   (req.name_lo),
    .in_name_hi   (req.name_hi),
    .rsp          (rsp)
  );

endmodule

### hdl/pgt_ctrl.sv
module pgt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pgt_pkg::stat_t  stat,
  output pgt_pkg::cmd_t   cmd
);

  pgt_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      pgt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_key = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = pgt_pkg::S_DISPATCH;
        end
      end
      pgt_pkg::S_DISPATCH: begin
        case (stat.key_cmd)
          pgt_pkg::CMD_OBSERVE: begin
            if (!stat.key_zero) begin
              state_next = pgt_pkg::S_LOOKUP;
            end else if (stat.out_free) begin
              cmd.ld_status = 1'b1;
              cmd.status_code = pgt_pkg::ST_IGNORED;
              state_next = pgt_pkg::S_IDLE;
            end
          end
          pgt_pkg::CMD_END_SCAN: begin
            if (!stat.empty) begin
              state_next = pgt_pkg::S_EOS_MARK;
            end else if (stat.out_free) begin
              cmd.ld_status = 1'b1;
              cmd.status_code = pgt_pkg::ST_EMPTY;
              state_next = pgt_pkg::S_IDLE;
            end
          end
          pgt_pkg::CMD_FIND: begin
            state_next = pgt_pkg::S_LOOKUP;
          end
          default: begin
            state_next = pgt_pkg::S_IDLE;
          end
        endcase
      end
      pgt_pkg::S_LOOKUP: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = pgt_pkg::S_DECIDE;
        end
      end
      pgt_pkg::S_DECIDE: begin
        if (stat.hit) begin
          state_next = pgt_pkg::S_READ_HIT;
        end else if (stat.out_free) begin
          state_next = pgt_pkg::S_IDLE;
          if (stat.key_cmd == pgt_pkg::CMD_FIND) begin
            cmd.ld_status = 1'b1;
            cmd.status_code = pgt_pkg::ST_NOT_FOUND;
          end else if (stat.free_found) begin
            cmd.ld_new = 1'b1;
          end else begin
            cmd.ld_status = 1'b1;
            cmd.status_code = pgt_pkg::ST_FULL;
          end
        end
      end
      pgt_pkg::S_READ_HIT: begin
        cmd.rd_en = 1'b1;
        if (stat.key_cmd == pgt_pkg::CMD_FIND) begin
          state_next = pgt_pkg::S_FIND_OUT;
        end else begin
          state_next = pgt_pkg::S_UPDATE;
        end
      end
      pgt_pkg::S_UPDATE: begin
        if (stat.out_free) begin
          cmd.ld_upd = 1'b1;
          state_next = pgt_pkg::S_IDLE;
        end
      end
      pgt_pkg::S_FIND_OUT: begin
        if (stat.out_free) begin
          cmd.ld_find = 1'b1;
          state_next = pgt_pkg::S_IDLE;
        end
      end
      pgt_pkg::S_EOS_MARK: begin
        cmd.eos_mark = 1'b1;
        cmd.scan_clr = 1'b1;
        state_next = pgt_pkg::S_SORT_SCAN;
      end
      pgt_pkg::S_SORT_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.mode_sort = 1'b1;
        if (stat.scan_done) begin
          state_next = pgt_pkg::S_SORT_READ;
        end
      end
      pgt_pkg::S_SORT_READ: begin
        cmd.rd_en = 1'b1;
        cmd.rd_best = 1'b1;
        state_next = pgt_pkg::S_SORT_EMIT;
      end
      pgt_pkg::S_SORT_EMIT: begin
        if (stat.out_free) begin
          cmd.ld_sort = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = stat.sort_last ? pgt_pkg::S_IDLE : pgt_pkg::S_SORT_SCAN;
        end
      end
      default: begin
        state_next = pgt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hdl/pgt_dpath.sv
`include "process_generation_tracker_unit_assert.svh"

module pgt_dpath (
  input  logic           clk,
  input  logic           rst,
  input  pgt_pkg::cmd_t  cmd,
  output pgt_pkg::stat_t stat,
  input  logic [1:0]     in_cmd,
  input  logic [31:0]    in_pid,
  input  logic [63:0]    in_page_base,
  input  logic [63:0]    in_env_block,
  input  logic [63:0]    in_name_lo,
  input  logic [63:0]    in_name_hi,
  pgt_rsp_if.source      rsp
);

  localparam int N = pgt_pkg::TABLE_ENTRIES;
  localparam int IW = pgt_pkg::IDX_W;
  localparam int CW = pgt_pkg::CNT_W;

  // Storage
  logic [31:0]           pid_mem [N];
  pgt_pkg::entry_t       data_mem [N];
  logic [N-1:0]          valid, seen, exited;
  logic [CW-1:0]         valid_cnt;

  // Captured item
  logic [1:0]  key_cmd;
  logic [31:0] key_pid;
  logic [63:0] key_base, key_env, key_name_lo, key_name_hi;

  // Scan pipeline and search results
  logic [CW-1:0] scan_cnt;
  logic          p_vld;
  logic [IW-1:0] p_idx;
  logic [31:0]   p_pid;
  logic          hit, free_found, best_found;
  logic [IW-1:0] hit_idx, free_idx, best_idx;
  logic [31:0]   best_pid;

  // Sorted dump progress
  logic [CW-1:0] emit_cnt;
  logic          have_prev;
  logic [31:0]   prev_pid;

  pgt_pkg::entry_t rd_data;
  pgt_pkg::entry_t wr_data;
  logic [31:0]     gen_upd;
  logic            out_valid, out_free, any_load;

  assign out_free = !out_valid || rsp.ready;
  assign any_load = cmd.ld_status || cmd.ld_new || cmd.ld_upd || cmd.ld_find || cmd.ld_sort;

  assign stat.scan_done = (scan_cnt == CW'(N)) && !p_vld;
  assign stat.hit = hit;
  assign stat.free_found = free_found;
  assign stat.out_free = out_free;
  assign stat.empty = (valid_cnt == '0);
  assign stat.sort_last = (CW'(emit_cnt + 1'b1) == valid_cnt);
  assign stat.key_zero = (key_pid == '0) || (key_base == '0);
  assign stat.key_cmd = key_cmd;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_cmd <= in_cmd;
      key_pid <= in_pid;
      key_base <= in_page_base;
      key_env <= in_env_block;
      key_name_lo <= in_name_lo;
      key_name_hi <= in_name_hi;
    end
  end

  // Advance the scan: read one pid per cycle into p_pid, then compare the registered pid
  always_ff @(posedge clk) begin
    if (rst || cmd.scan_clr) begin
      scan_cnt <= '0;
      p_vld <= 1'b0;
      hit <= 1'b0;
      free_found <= 1'b0;
      best_found <= 1'b0;
    end else if (cmd.scan_step) begin
      p_vld <= (scan_cnt < CW'(N));
      if (scan_cnt < CW'(N)) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (p_vld) begin
        if (cmd.mode_sort) begin
          if (valid[p_idx] && (!have_prev || p_pid > prev_pid) &&
              (!best_found || p_pid < best_pid)) begin
            best_found <= 1'b1;
          end
        end else begin
          if (valid[p_idx] && p_pid == key_pid && !hit) begin
            hit <= 1'b1;
          end
          if (!valid[p_idx] && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end
    end
  end

  // Scan payload: pid read port and search indexes
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      if (scan_cnt < CW'(N)) begin
        p_idx <= scan_cnt[IW-1:0];
        p_pid <= pid_mem[scan_cnt[IW-1:0]];
      end
      if (p_vld) begin
        if (cmd.mode_sort) begin
          if (valid[p_idx] && (!have_prev || p_pid > prev_pid) &&
              (!best_found || p_pid < best_pid)) begin
            best_idx <= p_idx;
            best_pid <= p_pid;
          end
        end else begin
          if (valid[p_idx] && p_pid == key_pid && !hit) begin
            hit_idx <= p_idx;
          end
          if (!valid[p_idx] && !free_found) begin
            free_idx <= p_idx;
          end
        end
      end
    end
  end

  // Entry write data for observe
  always_comb begin
    gen_upd = (rd_data.base != key_base || exited[hit_idx]) ? rd_data.gen + 32'd1
                                                            : rd_data.gen;
    wr_data.base = key_base;
    wr_data.env = key_env;
    wr_data.name_lo = key_name_lo;
    wr_data.name_hi = key_name_hi;
    wr_data.gen = cmd.ld_new ? 32'd1 : gen_upd;
  end

  // Entry memories
  always_ff @(posedge clk) begin
    if (cmd.ld_new) begin
      pid_mem[free_idx] <= key_pid;
      data_mem[free_idx] <= wr_data;
    end else if (cmd.ld_upd) begin
      data_mem[hit_idx] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= data_mem[cmd.rd_best ? best_idx : hit_idx];
    end
  end

  // Per-entry flags and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      seen <= '0;
      valid_cnt <= '0;
    end else if (cmd.eos_mark) begin
      seen <= '0;
    end else if (cmd.ld_new) begin
      valid[free_idx] <= 1'b1;
      seen[free_idx] <= 1'b1;
      valid_cnt <= valid_cnt + 1'b1;
    end else if (cmd.ld_upd) begin
      seen[hit_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eos_mark) begin
      exited <= exited | (valid & ~seen);
    end else if (cmd.ld_new) begin
      exited[free_idx] <= 1'b0;
    end else if (cmd.ld_upd) begin
      exited[hit_idx] <= 1'b0;
    end
  end

  // Sorted dump bookkeeping
  always_ff @(posedge clk) begin
    if (rst || cmd.eos_mark) begin
      emit_cnt <= '0;
      have_prev <= 1'b0;
    end else if (cmd.ld_sort) begin
      emit_cnt <= emit_cnt + 1'b1;
      have_prev <= 1'b1;
      prev_pid <= best_pid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (any_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_status) begin
      rsp.status <= cmd.status_code;
      rsp.out_pid <= '0;
      rsp.out_page_base <= '0;
      rsp.out_env_block <= '0;
      rsp.out_name_lo <= '0;
      rsp.out_name_hi <= '0;
      rsp.generation <= '0;
      rsp.exited <= 1'b0;
      rsp.last <= 1'b1;
    end else if (cmd.ld_new || cmd.ld_upd) begin
      rsp.status <= pgt_pkg::ST_OK;
      rsp.out_pid <= key_pid;
      rsp.out_page_base <= wr_data.base;
      rsp.out_env_block <= wr_data.env;
      rsp.out_name_lo <= wr_data.name_lo;
      rsp.out_name_hi <= wr_data.name_hi;
      rsp.generation <= wr_data.gen;
      rsp.exited <= 1'b0;
      rsp.last <= 1'b1;
    end else if (cmd.ld_find || cmd.ld_sort) begin
      rsp.status <= pgt_pkg::ST_OK;
      rsp.out_pid <= cmd.ld_sort ? best_pid : key_pid;
      rsp.out_page_base <= rd_data.base;
      rsp.out_env_block <= rd_data.env;
      rsp.out_name_lo <= rd_data.name_lo;
      rsp.out_name_hi <= rd_data.name_hi;
      rsp.generation <= rd_data.gen;
      rsp.exited <= cmd.ld_sort ? exited[best_idx] : exited[hit_idx];
      rsp.last <= cmd.ld_sort ? stat.sort_last : 1'b1;
    end
  end

  assign rsp.valid = out_valid;

  `PGT_ASSERT_ALWAYS(a_count_match, $countones(valid) == int'(valid_cnt), "occupancy mismatch")
  `PGT_ASSERT_IMPLY(a_load_free, any_load, out_free, "result load over pending result")
  `PGT_ASSERT_IMPLY(a_new_slot, cmd.ld_new, free_found && !valid[free_idx], "insert into used slot")
  `PGT_ASSERT_NEXT(a_load_shows, any_load, out_valid, "loaded result not presented")

endmodule

### bench/tb_process_generation_tracker_unit.sv
`timescale 1ns / 100ps

module tb_process_generation_tracker_unit;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int POOL = 24;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] pid;
    logic [63:0] base;
    logic [63:0] env;
    logic [63:0] nlo;
    logic [63:0] nhi;
  } proc_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] pid;
    logic [63:0] base;
    logic [63:0] env;
    logic [63:0] nlo;
    logic [63:0] nhi;
    logic [31:0] gen;
    logic        exited;
    logic        last;
  } proc_rsp_t;

  // Process table mirror and the queue of results it predicts
  class tracker_scoreboard;
    bit          slot_used [pgt_pkg::TABLE_ENTRIES];
    bit          slot_seen [pgt_pkg::TABLE_ENTRIES];
    bit          slot_gone [pgt_pkg::TABLE_ENTRIES];
    logic [31:0] slot_pid  [pgt_pkg::TABLE_ENTRIES];
    logic [63:0] slot_base [pgt_pkg::TABLE_ENTRIES];
    logic [63:0] slot_env  [pgt_pkg::TABLE_ENTRIES];
    logic [63:0] slot_nlo  [pgt_pkg::TABLE_ENTRIES];
    logic [63:0] slot_nhi  [pgt_pkg::TABLE_ENTRIES];
    logic [31:0] slot_gen  [pgt_pkg::TABLE_ENTRIES];
    proc_rsp_t   pending_rsp[$];
    int          errors;
    int          matched;
    int          full_hits;
    int          dumps;

    function new();
      for (int i = 0; i < pgt_pkg::TABLE_ENTRIES; i++) begin
        slot_used[i] = 0;
        slot_seen[i] = 0;
      end
      errors = 0;
      matched = 0;
      full_hits = 0;
      dumps = 0;
    endfunction

    function int used_count();
      int n;
      n = 0;
      for (int i = 0; i < pgt_pkg::TABLE_ENTRIES; i++) n += slot_used[i];
      return n;
    endfunction

    function int find_slot(logic [31:0] pid);
      for (int i = 0; i < pgt_pkg::TABLE_ENTRIES; i++)
        if (slot_used[i] && slot_pid[i] == pid) return i;
      return -1;
    endfunction

    function void push_status(logic [2:0] st);
      proc_rsp_t r;
      r = '{status: st, pid: '0, base: '0, env: '0, nlo: '0, nhi: '0,
            gen: '0, exited: 1'b0, last: 1'b1};
      pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    function void push_slot(int i, bit last);
      proc_rsp_t r;
      r = '{status: pgt_pkg::ST_OK, pid: slot_pid[i], base: slot_base[i], env: slot_env[i],
            nlo: slot_nlo[i], nhi: slot_nhi[i], gen: slot_gen[i],
            exited: slot_gone[i], last: last};
      pending_rsp.insert(pending_rsp.size(), r);
    endfunction

    // Update the mirror for one accepted request
    function void note(proc_req_t q);
      int i, n, pick;
      logic [31:0] prev;
      bit have_prev;
      case (q.cmd)
        pgt_pkg::CMD_OBSERVE: begin
          if (q.pid == 0 || q.base == 0) begin
            push_status(pgt_pkg::ST_IGNORED);
            return;
          end
          i = find_slot(q.pid);
          if (i < 0) begin
            for (i = 0; i < pgt_pkg::TABLE_ENTRIES; i++) if (!slot_used[i]) break;
            if (i >= pgt_pkg::TABLE_ENTRIES) begin
              full_hits++;
              push_status(pgt_pkg::ST_FULL);
              return;
            end
            slot_used[i] = 1;
            slot_pid[i] = q.pid;
            slot_gen[i] = 32'd1;
          end else if (slot_base[i] != q.base || slot_gone[i]) begin
            slot_gen[i] = slot_gen[i] + 32'd1;
          end
          slot_base[i] = q.base;
          slot_env[i] = q.env;
          slot_nlo[i] = q.nlo;
          slot_nhi[i] = q.nhi;
          slot_gone[i] = 0;
          slot_seen[i] = 1;
          push_slot(i, 1);
        end
        pgt_pkg::CMD_END_SCAN: begin
          dumps++;
          n = used_count();
          for (i = 0; i < pgt_pkg::TABLE_ENTRIES; i++) begin
            if (slot_used[i] && !slot_seen[i]) slot_gone[i] = 1;
            slot_seen[i] = 0;
          end
          if (n == 0) begin
            push_status(pgt_pkg::ST_EMPTY);
            return;
          end
          // emit in ascending pid order
          have_prev = 0;
          prev = '0;
          for (int k = 0; k < n; k++) begin
            pick = -1;
            for (i = 0; i < pgt_pkg::TABLE_ENTRIES; i++)
              if (slot_used[i] && (!have_prev || slot_pid[i] > prev) &&
                  (pick < 0 || slot_pid[i] < slot_pid[pick]))
                pick = i;
            push_slot(pick, k == n - 1);
            prev = slot_pid[pick];
            have_prev = 1;
          end
        end
        pgt_pkg::CMD_FIND: begin
          i = find_slot(q.pid);
          if (i < 0) push_status(pgt_pkg::ST_NOT_FOUND);
          else push_slot(i, 1);
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer against the oldest prediction
    function void check(proc_rsp_t a);
      proc_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result status=%0d pid=%h", $time, a.status, a.pid);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (a !== e) begin
        $display("%0t: result differs", $time);
        $display("  expected st=%0d pid=%h base=%h env=%h name=%h_%h gen=%0d ex=%b last=%b",
                 e.status, e.pid, e.base, e.env, e.nhi, e.nlo, e.gen, e.exited, e.last);
        $display("  actual   st=%0d pid=%h base=%h env=%h name=%h_%h gen=%0d ex=%b last=%b",
                 a.status, a.pid, a.base, a.env, a.nhi, a.nlo, a.gen, a.exited, a.last);
        errors++;
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   stall_left = 0;
  int   sent;

  pgt_req_if req ();
  pgt_rsp_if rsp ();

  tracker_scoreboard sb;

  logic [31:0] pid_pool  [POOL];
  logic [63:0] base_pool [POOL][3];

  process_generation_tracker_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Random stall bursts on the result side
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 4);
    end
  end

  // Pick up each result transfer
  always @(posedge clk) begin
    proc_rsp_t a;
    if (!rst && rsp.valid && rsp.ready) begin
      a = '{status: rsp.status, pid: rsp.out_pid, base: rsp.out_page_base,
            env: rsp.out_env_block, nlo: rsp.out_name_lo, nhi: rsp.out_name_hi,
            gen: rsp.generation, exited: rsp.exited, last: rsp.last};
      sb.check(a);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Hold one request until it is taken, with an optional idle burst first
  task automatic send(proc_req_t q);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= q.cmd;
    req.pid <= q.pid;
    req.page_base <= q.base;
    req.env_block <= q.env;
    req.name_lo <= q.nlo;
    req.name_hi <= q.nhi;
    do @(posedge clk); while (!req.ready);
    sb.note(q);
    if (q.cmd != CMD_UNUSED) sent++;
  endtask

  task automatic send_fields(logic [1:0] cmd, logic [31:0] pid, logic [63:0] base,
                             logic [63:0] env, logic [63:0] nlo, logic [63:0] nhi);
    proc_req_t q;
    q = '{cmd: cmd, pid: pid, base: base, env: env, nlo: nlo, nhi: nhi};
    send(q);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Mostly observes of a small pid pool so entries age through generations
  task automatic send_random();
    proc_req_t q;
    int p, r;
    p = $urandom_range(0, POOL - 1);
    r = $urandom_range(0, 99);
    q = '{cmd: pgt_pkg::CMD_OBSERVE, pid: pid_pool[p],
          base: base_pool[p][$urandom_range(0, 2)],
          env: rand64(), nlo: rand64(), nhi: rand64()};
    if (r < 6) q.pid = '0;
    else if (r < 10) q.base = '0;
    else if (r < 13) q.pid = $urandom;
    else if (r < 21) q.cmd = pgt_pkg::CMD_END_SCAN;
    else if (r < 36) q.cmd = pgt_pkg::CMD_FIND;
    else if (r < 39) q.cmd = CMD_UNUSED;
    if (q.cmd == pgt_pkg::CMD_FIND && r < 24) q.pid = $urandom;
    send(q);
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    quiet = 1'b0;
    sent = 0;
    req.valid <= 1'b0;
    req.cmd <= pgt_pkg::CMD_OBSERVE;
    req.pid <= '0;
    req.page_base <= '0;
    req.env_block <= '0;
    req.name_lo <= '0;
    req.name_hi <= '0;
    for (int i = 0; i < POOL; i++) begin
      pid_pool[i] = (i == 0) ? 32'hFFFF_FFFF : (i == 1) ? 32'd1 : $urandom;
      for (int j = 0; j < 3; j++) base_pool[i][j] = rand64();
    end
    base_pool[0][0] = '1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, ignored inputs, generation rules, extremes
    send_fields(pgt_pkg::CMD_END_SCAN, '0, '0, '0, '0, '0);
    send_fields(pgt_pkg::CMD_FIND, 32'd5, '0, '0, '0, '0);
    send_fields(pgt_pkg::CMD_OBSERVE, '0, 64'd7, '1, '1, '1);
    send_fields(pgt_pkg::CMD_OBSERVE, 32'd9, '0, '1, '1, '1);
    send_fields(pgt_pkg::CMD_OBSERVE, 32'hFFFF_FFFF, '1, '1, '1, '1);
    send_fields(pgt_pkg::CMD_OBSERVE, 32'd1, 64'd1, '0, '0, '0);
    send_fields(pgt_pkg::CMD_OBSERVE, 32'd1, 64'd1, 64'h55, 64'hAA, 64'h33);
    send_fields(pgt_pkg::CMD_OBSERVE, 32'd1, 64'd2, 64'h56, 64'hAB, 64'h34);
    send_fields(pgt_pkg::CMD_OBSERVE, 32'd300, 64'h1000, 64'h2000, 64'h6578652e, 64'h0);
    send_fields(pgt_pkg::CMD_FIND, 32'd1, '0, '0, '0, '0);
    send_fields(pgt_pkg::CMD_FIND, 32'hFFFF_FFFF, '0, '0, '0, '0);
    send_fields(CMD_UNUSED, 32'd1, 64'd3, '0, '0, '0);
    send_fields(pgt_pkg::CMD_END_SCAN, '0, '0, '0, '0, '0);
    send_fields(pgt_pkg::CMD_OBSERVE, 32'd300, 64'h1000, 64'h2000, 64'h1, 64'h2);
    send_fields(pgt_pkg::CMD_END_SCAN, '0, '0, '0, '0, '0);
    send_fields(pgt_pkg::CMD_OBSERVE, 32'd1, 64'd2, 64'h57, 64'hAC, 64'h35);
    send_fields(pgt_pkg::CMD_FIND, 32'd300, '0, '0, '0, '0);
    send_fields(pgt_pkg::CMD_END_SCAN, '0, '0, '0, '0, '0);

    // Random traffic over a small pid pool
    repeat (140) send_random();

    // Hold off until the block has answered everything
    drain();
    repeat (5) @(posedge clk);

    // Fill the table, then push new pids into a full table
    while (sb.used_count() < pgt_pkg::TABLE_ENTRIES)
      send_fields(pgt_pkg::CMD_OBSERVE, 32'h4000_0000 + sent, rand64() | 64'd1, rand64(),
                  rand64(), rand64());
    repeat (3) send_fields(pgt_pkg::CMD_OBSERVE, $urandom | 32'h8000_0000,
                           rand64() | 64'd1, rand64(), rand64(), rand64());
    send_fields(pgt_pkg::CMD_END_SCAN, '0, '0, '0, '0, '0);

    // Final stretch with no idling on either side
    quiet = 1'b1;
    repeat (30) send_random();
    req.valid <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d requests, %0d results checked, %0d table dumps, %0d full drops",
             sent, sb.matched, sb.dumps, sb.full_hits);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors,
               sb.pending_rsp.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30ms;
    $display("Timeout waiting for results");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/pgt_pkg.sv
hdl/pgt_req_if.sv
hdl/pgt_rsp_if.sv
hdl/pgt_ctrl.sv
hdl/pgt_dpath.sv
hdl/process_generation_tracker_unit.sv
bench/tb_process_generation_tracker_unit.sv
